// ===== sv/cht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants, codes and controller/datapath interface types for the
// three-way cuckoo hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int DEFAULT_TABLE_DEPTH  = 1024;
  localparam int DEFAULT_PAYLOAD_BITS = 32;

  localparam logic [1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [1:0] ACT_INSERT  = 2'd1;
  localparam logic [1:0] ACT_PAYLOAD = 2'd2;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_MISS     = 3'd2;
  localparam logic [2:0] ST_FAILED   = 3'd3;
  localparam logic [2:0] ST_WRITTEN  = 3'd4;

  localparam logic [1:0] REG_SLOTS  = 2'd0;
  localparam logic [1:0] REG_MOD2   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam logic [1:0] CLASS_VITAL = 2'd2;
  localparam logic [1:0] CLASS_BAD   = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH,
    S_HA, S_HAW, S_HT, S_HTW, S_HB, S_HBW, S_HC,
    S_PRB_RD, S_PRB_CHK,
    S_CST, S_CRD, S_CEV,
    S_CRA, S_CCA, S_CRB, S_CCB, S_CRC, S_CCC, S_CNX,
    S_FAIL, S_DWR, S_FP_RD, S_FP_CHK,
    S_PW_RD, S_PW_WR, S_EMIT
  } state_t;

  typedef enum logic [1:0] {DIV_A, DIV_M, DIV_B} div_sel_t;
  typedef enum logic [2:0] {CAP_NONE, CAP_A, CAP_T, CAP_B, CAP_C} cap_t;
  typedef enum logic [2:0] {
    ADDR_CAND, ADDR_WHERE, ADDR_HA, ADDR_HB, ADDR_HC, ADDR_SLOT
  } addr_sel_t;
  typedef enum logic [2:0] {
    WR_NONE, WR_CLR, WR_NEW, WR_EVICT, WR_DEST, WR_PAY
  } wr_sel_t;
  typedef enum logic [1:0] {DEST_NONE, DEST_A, DEST_B, DEST_C} dest_t;

  typedef struct packed {
    logic      accept;
    logic      clr;
    logic      div_start;
    div_sel_t  div_sel;
    cap_t      cap;
    logic      load_cand;
    logic      rd;
    addr_sel_t rsel;
    wr_sel_t   wr;
    logic      j_inc;
    logic      j_clr;
    logic      casc_init;
    logic      casc_next;
    dest_t     dest_set;
    logic      res_found;
    logic      res_new_j;
    logic      res_new_0;
    logic      res_fail;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       div_done;
    logic [1:0] action;
    logic       key_zero;
    logic       slot_ok;
    logic       rkey_match;
    logic       rkey_zero;
    logic       j_last;
    logic       j_two;
    logic [1:0] pc;
    logic       t_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/cht_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== sv/cht_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cht_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cht_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic      [31:0] rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [32:0] trial;

  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= 32'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[31:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/cht_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cht_datapath
// Configuration, hashing, slot table storage, cascade registers and results.
// ----------------------------------------------------------------------------
module cht_datapath
  import cht_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH,
  parameter int PAYLOAD_BITS = DEFAULT_PAYLOAD_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_key,
  input  wire logic [1:0]  in_importance,
  input  wire logic [9:0]  in_slot,
  input  wire logic [31:0] in_payload,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic      [2:0]  out_status,
  output logic      [9:0]  out_where,
  output logic      [31:0] out_payload,
  output logic      [31:0] out_lost_key,
  output logic      [1:0]  out_lost_class,
  output logic      [31:0] out_lost_payload,
  input  wire cmd_t        cmd,
  output sts_t             sts
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int AW1 = AW + 1;
  localparam int W   = 34 + PAYLOAD_BITS;

  logic [10:0] slots_in_use;
  logic [10:0] second_modulus;
  logic [9:0]  second_offset;
  logic [31:0] n_eff;
  logic [31:0] m_eff;

  logic [1:0]  action;
  logic [31:0] key;
  logic [1:0]  imp;
  logic [9:0]  slot;
  logic [PAYLOAD_BITS-1:0] payin;

  logic [31:0] hk;
  logic [AW-1:0] ha, hb, hc;
  logic [10:0] tm;
  logic [AW-1:0] cand [3];
  logic [1:0]  j;
  logic [AW-1:0] where_r;
  logic [AW-1:0] dest;
  logic [31:0] pk;
  logic [1:0]  pc;
  logic [PAYLOAD_BITS-1:0] pp;
  logic [AW1-1:0] t;
  logic [AW-1:0] clr_cnt;

  logic [2:0]  res_status;
  logic [9:0]  res_where;
  logic [31:0] res_pay;
  logic [31:0] res_lk;
  logic [1:0]  res_lc;
  logic [31:0] res_lp;

  logic        div_done;
  logic [31:0] div_rem;
  logic [31:0] div_dvd;
  logic [31:0] div_dsr;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic [W-1:0]  rdata;
  logic [31:0]   rkey;
  logic [1:0]    rcls;
  logic [PAYLOAD_BITS-1:0] rpay;
  logic [AW-1:0] cand_j;
  logic [AW1-1:0] csum;
  logic [AW1-1:0] nn;
  logic [AW-1:0] c_calc;
  logic [1:0]    lim;
  logic [1:0]    imp_in;

  always_comb begin
    n_eff = 32'(slots_in_use);
    if (slots_in_use == 11'd0) begin
      n_eff = 32'd1;
    end else if (32'(slots_in_use) > 32'(TABLE_DEPTH)) begin
      n_eff = 32'(TABLE_DEPTH);
    end
    m_eff = (second_modulus == 11'd0) ? 32'd1 : 32'(second_modulus);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use   <= 11'd1024;
      second_modulus <= 11'd768;
      second_offset  <= 10'd1;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_SLOTS:  slots_in_use   <= cfg_data;
        REG_MOD2:   second_modulus <= cfg_data;
        REG_OFFSET: second_offset  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign rkey   = rdata[31:0];
  assign rcls   = rdata[33:32];
  assign rpay   = rdata[W-1:34];
  assign cand_j = cand[j];
  assign nn     = AW1'(n_eff);
  assign csum   = {1'b0, ha} + {1'b0, hb};
  assign c_calc = (csum >= nn) ? AW'(csum - nn) : AW'(csum);
  assign imp_in = (in_importance == CLASS_BAD) ? 2'd0 : in_importance;

  always_comb begin
    div_dvd = hk;
    div_dsr = n_eff;
    unique case (cmd.div_sel)
      DIV_A: begin
        div_dvd = hk;
        div_dsr = n_eff;
      end
      DIV_M: begin
        div_dvd = hk;
        div_dsr = m_eff;
      end
      DIV_B: begin
        div_dvd = 32'(tm) + 32'(second_offset);
        div_dsr = n_eff;
      end
      default: ;
    endcase
  end

  cht_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    raddr = cand_j;
    unique case (cmd.rsel)
      ADDR_CAND:  raddr = cand_j;
      ADDR_WHERE: raddr = where_r;
      ADDR_HA:    raddr = ha;
      ADDR_HB:    raddr = hb;
      ADDR_HC:    raddr = hc;
      ADDR_SLOT:  raddr = AW'(slot);
      default: ;
    endcase
  end

  always_comb begin
    waddr = clr_cnt;
    wdata = '0;
    unique case (cmd.wr)
      WR_NONE: ;
      WR_CLR: begin
        waddr = clr_cnt;
        wdata = '0;
      end
      WR_NEW: begin
        waddr = cand_j;
        wdata = {{PAYLOAD_BITS{1'b0}}, imp, key};
      end
      WR_EVICT: begin
        waddr = where_r;
        wdata = {pp, pc, pk};
      end
      WR_DEST: begin
        waddr = dest;
        wdata = {pp, pc, pk};
      end
      WR_PAY: begin
        waddr = AW'(slot);
        wdata = {payin, rcls, rkey};
      end
      default: ;
    endcase
  end

  assign ram_we   = (cmd.wr != WR_NONE);
  assign ram_addr = ram_we ? waddr : raddr;

  cht_ram #(
    .WIDTH (W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action <= in_action;
      key    <= in_key;
      imp    <= imp_in;
      slot   <= in_slot;
      payin  <= PAYLOAD_BITS'(in_payload);
      hk     <= in_key;
      res_pay <= '0;
      res_lk  <= '0;
      res_lc  <= '0;
      res_lp  <= '0;
      res_where <= (in_action == ACT_PAYLOAD) ? in_slot : 10'd0;
      priority case (in_action)
        ACT_INSERT:  res_status <= ST_FAILED;
        ACT_PAYLOAD: res_status <= ST_WRITTEN;
        default:     res_status <= ST_MISS;
      endcase
    end
    unique case (cmd.cap)
      CAP_NONE: ;
      CAP_A: ha <= AW'(div_rem);
      CAP_T: tm <= div_rem[10:0];
      CAP_B: hb <= AW'(div_rem);
      CAP_C: begin
        hc <= c_calc;
        if (cmd.load_cand) begin
          cand[0] <= ha;
          cand[1] <= hb;
          cand[2] <= c_calc;
        end
      end
      default: ;
    endcase
    if (cmd.load_cand || cmd.j_clr) begin
      j <= 2'd0;
    end else if (cmd.j_inc) begin
      j <= j + 2'd1;
    end
    if (cmd.casc_init) begin
      where_r <= cand[0];
      pk      <= key;
      pc      <= imp;
      pp      <= '0;
      t       <= '0;
    end
    if (cmd.wr == WR_EVICT) begin
      pk <= rkey;
      pc <= (rcls == CLASS_BAD) ? 2'd0 : rcls;
      pp <= rpay;
      hk <= rkey;
    end
    if (cmd.casc_next) begin
      t <= t + AW1'(1);
      priority case (pc)
        2'd0:    where_r <= (where_r == ha) ? hb : (where_r == hb) ? hc : ha;
        2'd1:    where_r <= (where_r == ha) ? hb : ha;
        default: where_r <= ha;
      endcase
    end
    unique case (cmd.dest_set)
      DEST_NONE: ;
      DEST_A: dest <= ha;
      DEST_B: dest <= hb;
      DEST_C: dest <= hc;
      default: ;
    endcase
    if (cmd.res_found) begin
      res_status <= ST_FOUND;
      res_where  <= 10'(cand_j);
      res_pay    <= 32'(rpay);
    end
    if (cmd.res_new_j) begin
      res_status <= ST_INSERTED;
      res_where  <= 10'(cand_j);
    end
    if (cmd.res_new_0) begin
      res_status <= ST_INSERTED;
      res_where  <= 10'(cand[0]);
    end
    if (cmd.res_fail) begin
      res_lk <= pk;
      res_lc <= pc;
      res_lp <= 32'(pp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status       <= res_status;
      out_where        <= res_where;
      out_payload      <= res_pay;
      out_lost_key     <= res_lk;
      out_lost_class   <= res_lc;
      out_lost_payload <= res_lp;
    end
  end

  always_comb begin
    priority case (imp)
      2'd0:    lim = 2'd3;
      2'd1:    lim = 2'd2;
      default: lim = 2'd1;
    endcase
    if (action == ACT_LOOKUP) begin
      lim = 2'd3;
    end
  end

  always_comb begin
    sts.clr_last   = (clr_cnt == AW'(TABLE_DEPTH - 1));
    sts.div_done   = div_done;
    sts.action     = action;
    sts.key_zero   = (key == 32'd0);
    sts.slot_ok    = (32'(slot) < 32'(TABLE_DEPTH));
    sts.rkey_match = (rkey == key);
    sts.rkey_zero  = (rkey == 32'd0);
    sts.j_last     = (j == lim - 2'd1);
    sts.j_two      = (j == 2'd2);
    sts.pc         = pc;
    sts.t_last     = ((32'(t) + 32'd1) >= n_eff);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== sv/cht_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer for clearing, hashing, probing, eviction cascade and result hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl
  import cht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   casc;
  logic   casc_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      casc  <= 1'b0;
    end else begin
      state <= state_next;
      casc  <= casc_next;
    end
  end

  always_comb begin
    state_next = state;
    casc_next  = casc;
    unique case (state)
      S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
          casc_next  = 1'b0;
        end
      end
      S_DISPATCH: begin
        priority case (sts.action)
          ACT_LOOKUP, ACT_INSERT: state_next = sts.key_zero ? S_EMIT : S_HA;
          ACT_PAYLOAD:            state_next = sts.slot_ok ? S_PW_RD : S_EMIT;
          default:                state_next = S_EMIT;
        endcase
      end
      S_HA:  state_next = S_HAW;
      S_HAW: if (sts.div_done) state_next = S_HT;
      S_HT:  state_next = S_HTW;
      S_HTW: if (sts.div_done) state_next = S_HB;
      S_HB:  state_next = S_HBW;
      S_HBW: if (sts.div_done) state_next = S_HC;
      S_HC:  state_next = casc ? S_CRA : S_PRB_RD;
      S_PRB_RD: state_next = S_PRB_CHK;
      S_PRB_CHK: begin
        if (sts.rkey_match) begin
          state_next = S_EMIT;
        end else if (sts.action == ACT_INSERT && sts.rkey_zero) begin
          state_next = S_EMIT;
        end else if (sts.j_last) begin
          state_next = (sts.action == ACT_INSERT) ? S_CST : S_EMIT;
        end else begin
          state_next = S_PRB_RD;
        end
      end
      S_CST: begin
        state_next = S_CRD;
        casc_next  = 1'b1;
      end
      S_CRD: state_next = S_CEV;
      S_CEV: state_next = S_HA;
      S_CRA: state_next = S_CCA;
      S_CCA: begin
        if (sts.rkey_zero)             state_next = S_DWR;
        else if (sts.pc != CLASS_VITAL) state_next = S_CRB;
        else                           state_next = S_CNX;
      end
      S_CRB: state_next = S_CCB;
      S_CCB: begin
        if (sts.rkey_zero)        state_next = S_DWR;
        else if (sts.pc == 2'd0)  state_next = S_CRC;
        else                      state_next = S_CNX;
      end
      S_CRC: state_next = S_CCC;
      S_CCC: state_next = sts.rkey_zero ? S_DWR : S_CNX;
      S_CNX: state_next = sts.t_last ? S_FAIL : S_CRD;
      S_FAIL: state_next = S_EMIT;
      S_DWR: state_next = S_FP_RD;
      S_FP_RD: state_next = S_FP_CHK;
      S_FP_CHK: begin
        if (sts.rkey_match || sts.j_two) state_next = S_EMIT;
        else                             state_next = S_FP_RD;
      end
      S_PW_RD: state_next = S_PW_WR;
      S_PW_WR: state_next = S_EMIT;
      S_EMIT:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        cmd.wr  = WR_CLR;
      end
      S_IDLE:     cmd.accept = in_valid;
      S_DISPATCH: ;
      S_HA: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_A;
      end
      S_HAW: if (sts.div_done) cmd.cap = CAP_A;
      S_HT: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_M;
      end
      S_HTW: if (sts.div_done) cmd.cap = CAP_T;
      S_HB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_B;
      end
      S_HBW: if (sts.div_done) cmd.cap = CAP_B;
      S_HC: begin
        cmd.cap       = CAP_C;
        cmd.load_cand = !casc;
      end
      S_PRB_RD: begin
        cmd.rd   = 1'b1;
        cmd.rsel = ADDR_CAND;
      end
      S_PRB_CHK: begin
        if (sts.rkey_match) begin
          cmd.res_found = 1'b1;
        end else if (sts.action == ACT_INSERT && sts.rkey_zero) begin
          cmd.wr        = WR_NEW;
          cmd.res_new_j = 1'b1;
        end else if (!sts.j_last) begin
          cmd.j_inc = 1'b1;
        end
      end
      S_CST: cmd.casc_init = 1'b1;
      S_CRD: begin
        cmd.rd   = 1'b1;
        cmd.rsel = ADDR_WHERE;
      end
      S_CEV: cmd.wr = WR_EVICT;
      S_CRA: begin
        cmd.rd   = 1'b1;
        cmd.rsel = ADDR_HA;
      end
      S_CCA: if (sts.rkey_zero) cmd.dest_set = DEST_A;
      S_CRB: begin
        cmd.rd   = 1'b1;
        cmd.rsel = ADDR_HB;
      end
      S_CCB: if (sts.rkey_zero) cmd.dest_set = DEST_B;
      S_CRC: begin
        cmd.rd   = 1'b1;
        cmd.rsel = ADDR_HC;
      end
      S_CCC: if (sts.rkey_zero) cmd.dest_set = DEST_C;
      S_CNX:  cmd.casc_next = 1'b1;
      S_FAIL: cmd.res_fail  = 1'b1;
      S_DWR: begin
        cmd.wr    = WR_DEST;
        cmd.j_clr = 1'b1;
      end
      S_FP_RD: begin
        cmd.rd   = 1'b1;
        cmd.rsel = ADDR_CAND;
      end
      S_FP_CHK: begin
        if (sts.rkey_match)  cmd.res_new_j = 1'b1;
        else if (sts.j_two)  cmd.res_new_0 = 1'b1;
        else                 cmd.j_inc     = 1'b1;
      end
      S_PW_RD: begin
        cmd.rd   = 1'b1;
        cmd.rsel = ADDR_SLOT;
      end
      S_PW_WR: cmd.wr   = WR_PAY;
      S_EMIT:  cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/three_way_cuckoo_hash_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// three_way_cuckoo_hash_table_top
// Three-way cuckoo hash table with class-limited eviction cascade.
// ----------------------------------------------------------------------------
// Hashing one key runs three remainder passes plus a modular add for the third hash.
// Each cascade move adds one rehash plus up to three probes, for at most
// slots_in_use moves (clamped to 1..TABLE_DEPTH). One request at a time.
// After reset a clearing pass zeroes the table; requests wait until it ends,
// configuration writes are taken at any time.
module three_way_cuckoo_hash_table_top
  import cht_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH,
  parameter int PAYLOAD_BITS = DEFAULT_PAYLOAD_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [10:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // key[31:0], importance[33:32], slot[43:34], payload[75:44]
  input  wire logic [79:0]  s_tdata,
  // action[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // where[9:0], payload_out[41:10], lost_key[73:42], lost_class[75:74],
  // lost_payload[107:76]
  output logic      [111:0] m_tdata,
  // status[2:0]
  output logic      [2:0]   m_tuser
);

  cmd_t        cmd;
  sts_t        sts;
  logic [9:0]  o_where;
  logic [31:0] o_pay;
  logic [31:0] o_lk;
  logic [1:0]  o_lc;
  logic [31:0] o_lp;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cht_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (s_tuser),
    .in_key           (s_tdata[31:0]),
    .in_importance    (s_tdata[33:32]),
    .in_slot          (s_tdata[43:34]),
    .in_payload       (s_tdata[75:44]),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .out_status       (m_tuser),
    .out_where        (o_where),
    .out_payload      (o_pay),
    .out_lost_key     (o_lk),
    .out_lost_class   (o_lc),
    .out_lost_payload (o_lp),
    .cmd              (cmd),
    .sts              (sts)
  );

  assign m_tdata = {4'd0, o_lp, o_lc, o_lk, o_pay, o_where};

endmodule
`default_nettype wire
